### src/bsp_pkg.sv
// ---------------------------------------------------------------------------
// bsp_pkg: shared types and constants of the bank split transfer planner
// Device codes, register indexes, bank geometry and the microcode program.
// ---------------------------------------------------------------------------
package bsp_pkg;

   // Device codes
   localparam logic [2:0] DEV_RAM  = 3'd0;
   localparam logic [2:0] DEV_ROM  = 3'd1;
   localparam logic [2:0] DEV_PHYS = 3'd2;
   localparam int unsigned DEVICE_COUNT = 3;

   // Configuration register indexes
   localparam logic [1:0] CSR_RAM_START = 2'd0;
   localparam logic [1:0] CSR_RAM_COUNT = 2'd1;
   localparam logic [1:0] CSR_ROM_START = 2'd2;
   localparam logic [1:0] CSR_ROM_COUNT = 2'd3;

   // Geometry
   localparam int unsigned BANK_BYTES  = 16384;
   localparam int unsigned BANK_BITS   = 14;
   localparam int unsigned BLOCK_BYTES = 512;
   localparam int unsigned BLOCK_BITS  = 9;
   localparam int unsigned MAX_CHUNKS  = 10;
   localparam logic [20:0] PHYS_LIMIT  = 21'h10_0000;

   // Microcode step addresses
   typedef logic [2:0] step_type;
   localparam step_type STEP_IDLE  = 3'd0;
   localparam step_type STEP_CALC  = 3'd1;
   localparam step_type STEP_TEST  = 3'd2;
   localparam step_type STEP_CHUNK = 3'd3;
   localparam step_type STEP_FAIL  = 3'd4;

   // Datapath operations
   typedef enum logic [1:0] {
      OP_NONE,
      OP_LOAD,
      OP_CALC,
      OP_ADV
   } op_type;

   // Jump conditions
   typedef enum logic [1:0] {
      CC_ALWAYS,
      CC_START,
      CC_BAD,
      CC_LAST
   } cond_type;

   // One control word
   typedef struct packed {
      logic     emit;
      logic     fail;
      op_type   op;
      cond_type cond;
      step_type jmp;
      step_type seq;
   } ctl_type;

   // Status the datapath reports to the sequencer
   typedef struct packed {
      logic start;
      logic bad;
      logic last;
   } flags_type;

   // Microcode program: next step is jmp when the condition holds, else seq
   function automatic ctl_type program_word(input step_type step);
      ctl_type w;
      w = '{emit: 1'b0, fail: 1'b0, op: OP_NONE, cond: CC_ALWAYS,
            jmp: STEP_IDLE, seq: STEP_IDLE};
      case (step)
         STEP_IDLE: begin
            w.op   = OP_LOAD;
            w.cond = CC_START;
            w.jmp  = STEP_CALC;
            w.seq  = STEP_IDLE;
         end
         STEP_CALC: begin
            w.op   = OP_CALC;
            w.cond = CC_ALWAYS;
            w.jmp  = STEP_TEST;
         end
         STEP_TEST: begin
            w.cond = CC_BAD;
            w.jmp  = STEP_FAIL;
            w.seq  = STEP_CHUNK;
         end
         STEP_CHUNK: begin
            w.emit = 1'b1;
            w.op   = OP_ADV;
            w.cond = CC_LAST;
            w.jmp  = STEP_IDLE;
            w.seq  = STEP_CHUNK;
         end
         STEP_FAIL: begin
            w.emit = 1'b1;
            w.fail = 1'b1;
            w.cond = CC_ALWAYS;
            w.jmp  = STEP_IDLE;
         end
         default: begin
            w.cond = CC_ALWAYS;
            w.jmp  = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

### src/bank_split_transfer_planner.sv
// ---------------------------------------------------------------------------
// bank_split_transfer_planner: plans one memory-disk transfer request
// Checks a request and splits it into chunks that never cross a 16 KiB
// bank boundary of source or destination.
// ---------------------------------------------------------------------------
// Usage:
//   Configure the RAM and ROM disk windows on the csr_ port while idle.
//   A request is taken at a clock edge where start is high and busy low.
//   The request is latched, then the source address and device limit are
//   formed, then the start address is checked, each step registered.
//   Results follow one per cycle on the rsp_ ports, each marked by
//   rsp_strobe for exactly one cycle; rsp_last_chunk flags the final one.
//   A rejected request gives a single result with rsp_failed high.
//   A request gives 1 to 10 results; the chunk step of the microcode
//   program runs once per result of an accepted request, and busy stays
//   high until the final result is shown, so the next request cannot be
//   taken before then.
//   The receiver cannot stall: results are shown once and dropped.
//   Synchronous reset returns the sequencer to idle and clears the
//   configuration registers and the result strobe.
// ---------------------------------------------------------------------------
module bank_split_transfer_planner (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_device,
   input  logic        req_user_path,
   input  logic        req_write_dir,
   input  logic [15:0] req_dest_base,
   input  logic [31:0] req_byte_offset,
   input  logic [15:0] req_block_number,
   input  logic [15:0] req_byte_count,
   // Result channel
   output logic        rsp_strobe,
   output logic        rsp_failed,
   output logic [31:0] rsp_source_address,
   output logic [15:0] rsp_dest_address,
   output logic [14:0] rsp_chunk_length,
   output logic        rsp_to_user,
   output logic [15:0] rsp_return_value,
   output logic        rsp_last_chunk,
   // Configuration port
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);
   import bsp_pkg::*;

   // Configuration registers
   logic [5:0]  ram_start_ff;
   logic [6:0]  ram_count_ff;
   logic [5:0]  rom_start_ff;
   logic [6:0]  rom_count_ff;

   // Latched request
   logic [2:0]  dev_ff;
   logic        user_path_ff;
   logic        write_dir_ff;
   logic [15:0] dest_base_ff;
   logic [31:0] offset_ff;
   logic [15:0] block_ff;
   logic [15:0] count_ff;

   // Working state
   logic        bad_dev_ff;
   logic [20:0] limit_ff;
   logic [31:0] src_ff;
   logic [15:0] dst_ff;
   logic [15:0] rem_ff;
   logic [15:0] rv_ff;
   logic        user_ff;
   logic [3:0]  chunk_ff;

   // Result registers
   logic        strobe_ff;
   logic        failed_ff;
   logic [31:0] out_src_ff;
   logic [15:0] out_dst_ff;
   logic [14:0] out_len_ff;
   logic        out_user_ff;
   logic [15:0] out_rv_ff;
   logic        out_last_ff;

   ctl_type     ctl;
   flags_type   flags;
   logic        idle;

   // Calculation step signals
   logic        use_off;
   logic [5:0]  sel_start;
   logic [6:0]  sel_count;
   logic [6:0]  bank_sum;
   logic [31:0] start_addr;
   logic [20:0] limit_in;
   logic [31:0] src_in;
   logic [15:0] rem_in;
   logic [15:0] rv_in;

   // Chunk step signals
   logic [13:0] used;
   logic [14:0] room;
   logic [14:0] len;
   logic [15:0] rem_next;
   logic        last;

   bsp_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl),
      .idle  (idle)
   );

   assign busy = !idle;

   // Form the device window and source start
   always_comb begin
      use_off = user_path_ff || (dev_ff == DEV_PHYS);
      if (dev_ff == DEV_ROM) begin
         sel_start = rom_start_ff;
         sel_count = rom_count_ff;
      end else begin
         sel_start = ram_start_ff;
         sel_count = ram_count_ff;
      end
      bank_sum = {1'b0, sel_start} + sel_count;
      if (dev_ff == DEV_PHYS) begin
         start_addr = '0;
         limit_in   = PHYS_LIMIT;
      end else begin
         start_addr = {12'b0, sel_start, {BANK_BITS{1'b0}}};
         limit_in   = {bank_sum, {BANK_BITS{1'b0}}};
      end
      src_in = start_addr + (use_off ? offset_ff
                                     : {7'b0, block_ff, {BLOCK_BITS{1'b0}}});
      rem_in = use_off ? count_ff : 16'(BLOCK_BYTES);
      if (dev_ff == DEV_PHYS) begin
         rv_in = count_ff;
      end else if (user_path_ff) begin
         rv_in = {{BLOCK_BITS{1'b0}}, count_ff[15:BLOCK_BITS]};
      end else begin
         rv_in = 16'd1;
      end
   end

   // Size the next chunk against both bank boundaries
   always_comb begin
      used = (dst_ff[13:0] > src_ff[13:0]) ? dst_ff[13:0] : src_ff[13:0];
      room = 15'(BANK_BYTES) - {1'b0, used};
      len  = (rem_ff > {1'b0, room}) ? room : rem_ff[14:0];
      rem_next = rem_ff - {1'b0, len};
      last = (rem_next == 16'd0) || (chunk_ff == 4'(MAX_CHUNKS - 1));
   end

   assign flags.start = start;
   assign flags.bad   = bad_dev_ff || ({11'b0, limit_ff} <= src_ff);
   assign flags.last  = last;

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         ram_start_ff <= '0;
         ram_count_ff <= '0;
         rom_start_ff <= '0;
         rom_count_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_RAM_START: ram_start_ff <= csr_data[5:0];
            CSR_RAM_COUNT: ram_count_ff <= csr_data;
            CSR_ROM_START: rom_start_ff <= csr_data[5:0];
            CSR_ROM_COUNT: rom_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Datapath driven by the control word
   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_LOAD: begin
            dev_ff       <= req_device;
            user_path_ff <= req_user_path;
            write_dir_ff <= req_write_dir;
            dest_base_ff <= req_dest_base;
            offset_ff    <= req_byte_offset;
            block_ff     <= req_block_number;
            count_ff     <= req_byte_count;
         end
         OP_CALC: begin
            bad_dev_ff <= (dev_ff >= 3'(DEVICE_COUNT)) ||
                          ((dev_ff == DEV_ROM) && write_dir_ff);
            limit_ff   <= limit_in;
            src_ff     <= src_in;
            dst_ff     <= dest_base_ff;
            rem_ff     <= rem_in;
            rv_ff      <= rv_in;
            user_ff    <= use_off;
            chunk_ff   <= '0;
         end
         OP_ADV: begin
            src_ff   <= src_ff + {17'b0, len};
            dst_ff   <= dst_ff + {1'b0, len};
            rem_ff   <= rem_next;
            chunk_ff <= chunk_ff + 4'd1;
         end
         default: ;
      endcase
   end

   // Register results
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl.emit;
      end
      if (ctl.fail) begin
         failed_ff   <= 1'b1;
         out_src_ff  <= '0;
         out_dst_ff  <= '0;
         out_len_ff  <= '0;
         out_user_ff <= 1'b0;
         out_rv_ff   <= '0;
         out_last_ff <= 1'b1;
      end else begin
         failed_ff   <= 1'b0;
         out_src_ff  <= src_ff;
         out_dst_ff  <= dst_ff;
         out_len_ff  <= len;
         out_user_ff <= user_ff;
         out_rv_ff   <= rv_ff;
         out_last_ff <= last;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_failed         = failed_ff;
   assign rsp_source_address = out_src_ff;
   assign rsp_dest_address   = out_dst_ff;
   assign rsp_chunk_length   = out_len_ff;
   assign rsp_to_user        = out_user_ff;
   assign rsp_return_value   = out_rv_ff;
   assign rsp_last_chunk     = out_last_ff;

   // Checks
   a_fail_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_failed |-> rsp_last_chunk)
      else $error("failed result without last flag");

   a_src_in_bank: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_failed |->
         ({1'b0, rsp_source_address[13:0]} + rsp_chunk_length) <= 15'(BANK_BYTES))
      else $error("chunk crosses a source bank boundary");

   a_dst_in_bank: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_failed |->
         ({1'b0, rsp_dest_address[13:0]} + rsp_chunk_length) <= 15'(BANK_BYTES))
      else $error("chunk crosses a destination bank boundary");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted without going busy");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_chunk |-> !busy)
      else $error("busy after final result");

endmodule

### src/bsp_seq.sv
// ---------------------------------------------------------------------------
// bsp_seq: microcode sequencer of the bank split transfer planner
// Holds the step counter, reads the control word from the program table
// and resolves the conditional jump from the datapath flags.
// ---------------------------------------------------------------------------
module bsp_seq (
   input  logic               clock,
   input  logic               reset,
   input  bsp_pkg::flags_type flags,
   output bsp_pkg::ctl_type   ctl,
   output logic               idle
);
   import bsp_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     taken;

   // Fetch the control word of the current step
   assign ctl  = program_word(step_ff);
   assign idle = (step_ff == STEP_IDLE);

   // Evaluate the jump condition
   always_comb begin
      case (ctl.cond)
         CC_ALWAYS: taken = 1'b1;
         CC_START:  taken = flags.start;
         CC_BAD:    taken = flags.bad;
         CC_LAST:   taken = flags.last;
         default:   taken = 1'b1;
      endcase
      step_in = taken ? ctl.jmp : ctl.seq;
   end

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
